[design/sfpm_pkg.sv]
package sfpm_pkg;

    // Fixed widths of the transaction fields.
    localparam int SLOT_W    = 4;
    localparam int MAX_SLOTS = 16;
    localparam int FLAGS_W   = 14;
    localparam int MASK_W    = 15;
    localparam int LIMIT_W   = 16;
    localparam int THRESH_W  = 11;

    // Operation codes; codes above OP_CONFIG all re-evaluate the pins.
    localparam logic [2:0] OP_ASSIGN   = 3'd0;
    localparam logic [2:0] OP_UNASSIGN = 3'd1;
    localparam logic [2:0] OP_CABLE    = 3'd2;
    localparam logic [2:0] OP_CONFIG   = 3'd3;

    // Function codes accepted by an assign.
    localparam logic [7:0] FUNC_OR  = 8'h08;
    localparam logic [7:0] FUNC_AND = 8'h09;

    // Configuration register indexes.
    localparam logic CFG_CHARGER_LIMIT   = 1'b0;
    localparam logic CFG_CHARGER_CHECKED = 1'b1;

    // Enumerated limit used while the device is not configured.
    localparam logic [LIMIT_W-1:0] DEFAULT_ENUM_MA = 16'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    // One stored pin entry.
    typedef struct packed {
        logic                is_and;
        logic                active_hi;
        logic [MASK_W-1:0]   mask;
        logic [MASK_W-1:0]   inv;
        logic [THRESH_W-1:0] thresh;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic walk;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eval_op;
        logic walk_last;
        logic out_busy;
    } t_stat;

endpackage

[design/sfpm_ctrl.sv]
module sfpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sfpm_pkg::t_stat i_stat,
    output sfpm_pkg::t_cmd  o_cmd
);
    import sfpm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.eval_op ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hand the result over once the output register is free.
                if (!i_stat.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/sfpm_dp.sv]
module sfpm_dp #(
    parameter int SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfpm_pkg::t_cmd                      i_cmd,
    output sfpm_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [sfpm_pkg::LIMIT_W-1:0]        i_cfg_data,
    input  logic [2:0]                          i_operation,
    input  logic [sfpm_pkg::SLOT_W-1:0]         i_slot,
    input  logic [7:0]                          i_function_code,
    input  logic                                i_active_high,
    input  logic [sfpm_pkg::MASK_W-1:0]         i_flag_mask,
    input  logic [sfpm_pkg::MASK_W-1:0]         i_invert_mask,
    input  logic [9:0]                          i_threshold_code,
    input  logic [8:0]                          i_cable_flags,
    input  logic [sfpm_pkg::LIMIT_W-1:0]        i_limit_ma,
    input  logic                                i_configured,
    input  logic                                i_protocol_error,
    input  logic                                i_charger_attached,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [SLOTS-1:0]                    o_pin_levels,
    output logic [sfpm_pkg::FLAGS_W-1:0]        o_status_flags,
    output logic [sfpm_pkg::LIMIT_W-1:0]        o_current_limit_ma,
    output logic                                o_accepted
);
    import sfpm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);

    // Configuration registers.
    logic [LIMIT_W-1:0] r_chg_cfg;
    logic               r_checked;

    // Flag and limit state.
    logic [8:0]         r_cable_f;
    logic               r_enum_f;
    logic               r_chg_f;
    logic               r_proto_f;
    logic [LIMIT_W-1:0] r_cable_lim;
    logic [LIMIT_W-1:0] r_enum_lim;
    logic [LIMIT_W-1:0] r_best;

    // Pin table, enables and levels.
    t_entry             r_table [SLOTS];
    logic [SLOTS-1:0]   r_en;
    logic [SLOTS-1:0]   r_pins;
    logic [IW-1:0]      r_idx;
    logic               r_acc;

    // Output register.
    logic               r_out_valid;
    logic [SLOTS-1:0]   r_out_pins;
    logic [FLAGS_W-1:0] r_out_flags;
    logic [LIMIT_W-1:0] r_out_lim;
    logic               r_out_acc;

    // Decoded transaction.
    logic               slot_ok;
    logic               func_ok;
    logic               eval_op;
    logic [IW-1:0]      slot_idx;
    t_entry             new_entry;

    // Next flag and limit values of an evaluating transaction.
    logic [8:0]         n_cable_f;
    logic               n_enum_f;
    logic [LIMIT_W-1:0] n_cable_lim;
    logic [LIMIT_W-1:0] n_enum_lim;
    logic [LIMIT_W-1:0] n_chg_lim;
    logic [LIMIT_W-1:0] max_ec;
    logic [LIMIT_W-1:0] n_best;

    // Per-entry evaluation.
    logic [FLAGS_W-1:0] flags;
    t_entry             cur;
    logic               capable;
    logic [MASK_W-1:0]  masked;
    logic               hit;
    logic               level;

    assign slot_ok   = {1'b0, i_slot} < SLOT_LIMIT;
    assign func_ok   = (i_function_code == FUNC_OR) || (i_function_code == FUNC_AND);
    assign eval_op   = (i_operation != OP_ASSIGN) && (i_operation != OP_UNASSIGN);
    assign slot_idx  = i_slot[IW-1:0];

    assign new_entry.is_and    = (i_function_code == FUNC_AND);
    assign new_entry.active_hi = i_active_high;
    assign new_entry.mask      = i_flag_mask;
    assign new_entry.inv       = i_invert_mask;
    assign new_entry.thresh    = {i_threshold_code, 1'b0};

    // Flag and limit update, then the largest of the three limits.
    always_comb begin
        n_cable_f   = r_cable_f;
        n_cable_lim = r_cable_lim;
        n_enum_f    = r_enum_f;
        n_enum_lim  = r_enum_lim;
        if (i_operation == OP_CABLE) begin
            n_cable_f   = i_cable_flags;
            n_cable_lim = i_limit_ma;
        end
        if (i_operation == OP_CONFIG) begin
            n_enum_f   = i_configured;
            n_enum_lim = i_configured ? i_limit_ma : DEFAULT_ENUM_MA;
        end
        n_chg_lim = i_charger_attached ? r_chg_cfg : '0;
        max_ec    = (n_enum_lim > n_chg_lim) ? n_enum_lim : n_chg_lim;
        n_best    = (n_cable_lim > max_ec) ? n_cable_lim : max_ec;
    end

    // Level of the entry under the walk index; bit 14 is the capability flag.
    assign flags   = {r_proto_f, r_enum_f, 1'b0, r_chg_f, r_checked, r_cable_f};
    assign cur     = r_table[r_idx];
    assign capable = r_best >= {{(LIMIT_W - THRESH_W){1'b0}}, cur.thresh};
    assign masked  = ({capable, flags} ^ cur.inv) & cur.mask;
    assign hit     = cur.is_and ? (masked == cur.mask) : (masked != '0);
    assign level   = ~(hit ^ cur.active_hi);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_cfg <= '0;
            r_checked <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CHARGER_LIMIT) begin
                r_chg_cfg <= i_cfg_data;
            end else begin
                r_checked <= i_cfg_data[0];
            end
        end
    end

    // Flag and limit registers, taken with an evaluating transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable_f   <= '0;
            r_enum_f    <= 1'b0;
            r_chg_f     <= 1'b0;
            r_proto_f   <= 1'b0;
            r_cable_lim <= '0;
            r_enum_lim  <= '0;
            r_best      <= '0;
        end else if (i_cmd.accept && eval_op) begin
            r_cable_f   <= n_cable_f;
            r_enum_f    <= n_enum_f;
            r_chg_f     <= i_charger_attached;
            r_proto_f   <= i_protocol_error;
            r_cable_lim <= n_cable_lim;
            r_enum_lim  <= n_enum_lim;
            r_best      <= n_best;
        end
    end

    // Entry payload; only enabled entries are ever read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_operation == OP_ASSIGN) && slot_ok && func_ok) begin
            r_table[slot_idx] <= new_entry;
        end
    end

    // Entry enables, walk index, pin levels and the accepted flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '0;
            r_pins <= '0;
            r_idx  <= '0;
            r_acc  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
                r_acc <= (i_operation == OP_ASSIGN) && slot_ok && func_ok;
                if (slot_ok && (i_operation == OP_ASSIGN) && func_ok) begin
                    r_en[slot_idx] <= 1'b1;
                end
                if (slot_ok && (i_operation == OP_UNASSIGN)) begin
                    r_en[slot_idx] <= 1'b0;
                end
            end
            if (i_cmd.walk) begin
                r_idx <= r_idx + 1'b1;
                if (r_en[r_idx]) begin
                    r_pins[r_idx] <= level;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_pins  <= r_pins;
            r_out_flags <= flags;
            r_out_lim   <= r_best;
            r_out_acc   <= r_acc;
        end
    end

    assign o_stat.eval_op   = eval_op;
    assign o_stat.walk_last = (r_idx == IW'(SLOTS - 1));
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_pin_levels       = r_out_pins;
    assign o_status_flags     = r_out_flags;
    assign o_current_limit_ma = r_out_lim;
    assign o_accepted         = r_out_acc;

endmodule

[design/status_flag_pin_mapper_top.sv]
// Sequence: an assign or unassign goes from idle straight to the finish state; an evaluating
// operation first walks the pin entries, one entry per cycle, then finishes. The finish state
// loads the result into the output register once that register is free, and a new transaction
// is taken only in idle, after the result of the last one has been loaded.
// Reset: synchronous, active low; all entries disabled, flags, limits and pin levels cleared.
module status_flag_pin_mapper_top #(
    parameter int PIN_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [2:0]   i_operation,
    input  logic [3:0]   i_slot,
    input  logic [7:0]   i_function_code,
    input  logic         i_active_high,
    input  logic [14:0]  i_flag_mask,
    input  logic [14:0]  i_invert_mask,
    input  logic [9:0]   i_threshold_code,
    input  logic [8:0]   i_cable_flags,
    input  logic [15:0]  i_limit_ma,
    input  logic         i_configured,
    input  logic         i_protocol_error,
    input  logic         i_charger_attached,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [15:0]  o_pin_levels,
    output logic [13:0]  o_status_flags,
    output logic [15:0]  o_current_limit_ma,
    output logic         o_accepted
);
    import sfpm_pkg::*;

    // Slots above the reach of the slot field are never used.
    localparam int SLOTS = (PIN_SLOTS < MAX_SLOTS) ? PIN_SLOTS : MAX_SLOTS;

    t_cmd             cmd;
    t_stat            stat;
    logic [SLOTS-1:0] pins;

    // Sequencer.
    sfpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Flags, limits, pin table and output register.
    sfpm_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_function_code    (i_function_code),
        .i_active_high      (i_active_high),
        .i_flag_mask        (i_flag_mask),
        .i_invert_mask      (i_invert_mask),
        .i_threshold_code   (i_threshold_code),
        .i_cable_flags      (i_cable_flags),
        .i_limit_ma         (i_limit_ma),
        .i_configured       (i_configured),
        .i_protocol_error   (i_protocol_error),
        .i_charger_attached (i_charger_attached),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_pin_levels       (pins),
        .o_status_flags     (o_status_flags),
        .o_current_limit_ma (o_current_limit_ma),
        .o_accepted         (o_accepted)
    );

    assign o_pin_levels = 16'(pins);

endmodule
